[hdl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check pre -> post in the same cycle, sampled on clk, off while rst is high.
`define ASSERT_SAME(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed");

// Check pre -> post in the next cycle.
`define ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

[hdl/itar_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package itar_pkg;

  localparam int VALUE_W = 32;
  localparam int DIGIT_DEPTH = 32;
  localparam int IDX_W = $clog2(DIGIT_DEPTH);

  // mode codes
  localparam logic [2:0] OP_BIN    = 3'd0;
  localparam logic [2:0] OP_OCT    = 3'd1;
  localparam logic [2:0] OP_UDEC   = 3'd2;
  localparam logic [2:0] OP_SDEC   = 3'd3;
  localparam logic [2:0] OP_HEX_LO = 3'd4;
  localparam logic [2:0] OP_HEX_UP = 3'd5;

  // floor(n / 10) == (n * RECIP_10) >> RECIP_SHIFT for any 32-bit n
  localparam logic [31:0] RECIP_10 = 32'hCCCC_CCCD;
  localparam int RECIP_SHIFT = 35;

  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_UPPER = 8'h41;
  localparam logic [7:0] CHAR_LOWER = 8'h61;

  typedef struct packed {
    logic load;        // take a new transaction
    logic mul;         // register num * reciprocal
    logic digit;       // peel one digit into the store
    logic emit_sign;   // load '-' into the output register
    logic emit_digit;  // load next stored digit into the output register
  } cmd_t;

  typedef struct packed {
    logic op_ok;    // incoming op is a defined mode
    logic in_dec;   // incoming op is decimal
    logic dec;      // current transaction is decimal
    logic neg;      // current transaction needs a leading '-'
    logic done;     // this digit step is the last one
    logic rd_zero;  // read pointer sits on the least significant digit
    logic out_free; // output register can take a character this cycle
  } status_t;

  function automatic logic [7:0] ascii_digit(input logic [3:0] d, input logic upper);
    logic [7:0] base;
    begin
      base = upper ? CHAR_UPPER : CHAR_LOWER;
      if (d < 4'd10) begin
        ascii_digit = CHAR_ZERO + {4'd0, d};
      end else begin
        ascii_digit = base + {4'd0, d} - 8'd10;
      end
    end
  endfunction

endpackage

`default_nettype wire

[hdl/itar_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module itar_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  itar_pkg::status_t  status,
  output itar_pkg::cmd_t     cmd
);

  typedef enum logic [2:0] {
    IDLE,
    MUL,
    DIG,
    PREP,
    SIGN,
    EMIT
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    in_ready   = 1'b0;
    state_next = state;
    case (state)
      IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          // undefined modes are taken and dropped
          if (status.op_ok) begin
            state_next = status.in_dec ? MUL : DIG;
          end
        end
      end
      MUL: begin
        cmd.mul    = 1'b1;
        state_next = DIG;
      end
      DIG: begin
        cmd.digit = 1'b1;
        if (status.done) begin
          state_next = PREP;
        end else begin
          state_next = status.dec ? MUL : DIG;
        end
      end
      PREP: begin
        // store read of the most significant digit is in flight
        state_next = status.neg ? SIGN : EMIT;
      end
      SIGN: begin
        if (status.out_free) begin
          cmd.emit_sign = 1'b1;
          state_next    = EMIT;
        end
      end
      EMIT: begin
        if (status.out_free) begin
          cmd.emit_digit = 1'b1;
          if (status.rd_zero) begin
            state_next = IDLE;
          end
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

[hdl/itar_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none

module itar_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [2:0]                    op,
  input  logic [itar_pkg::VALUE_W-1:0]  value,
  input  itar_pkg::cmd_t                cmd,
  output itar_pkg::status_t             status,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [7:0]                    character,
  output logic                          last,
  output logic [31:0]                   char_count
);

  logic [itar_pkg::VALUE_W-1:0]   num;
  logic [2*itar_pkg::VALUE_W-1:0] prod;
  logic [2:0]                     shamt;
  logic                           is_dec;
  logic                           upper;
  logic                           neg;
  logic [itar_pkg::IDX_W-1:0]     wr_idx;
  logic [itar_pkg::IDX_W-1:0]     rd_idx;
  logic [3:0]                     rd_data;
  logic [3:0]                     mem [itar_pkg::DIGIT_DEPTH];

  logic [2:0]                     in_shamt;
  logic                           in_dec;
  logic                           in_neg;
  logic                           op_ok;
  logic [itar_pkg::VALUE_W-1:0]   quot;
  logic [3:0]                     q10_lo;
  logic [3:0]                     rem;
  logic [3:0]                     dmask;
  logic [3:0]                     digit;
  logic [itar_pkg::VALUE_W-1:0]   num_next;
  logic [itar_pkg::IDX_W-1:0]     rd_addr;
  logic                           out_free;

  // decode the incoming mode
  always_comb begin
    in_shamt = 3'd4;
    in_dec   = 1'b0;
    case (op)
      itar_pkg::OP_BIN:    in_shamt = 3'd1;
      itar_pkg::OP_OCT:    in_shamt = 3'd3;
      itar_pkg::OP_UDEC:   in_dec   = 1'b1;
      itar_pkg::OP_SDEC:   in_dec   = 1'b1;
      itar_pkg::OP_HEX_LO: in_shamt = 3'd4;
      itar_pkg::OP_HEX_UP: in_shamt = 3'd4;
      default:             in_shamt = 3'd4;
    endcase
    op_ok  = op inside {[itar_pkg::OP_BIN:itar_pkg::OP_HEX_UP]};
    in_neg = (op == itar_pkg::OP_SDEC) && value[itar_pkg::VALUE_W-1];
  end

  // one digit step: reciprocal quotient for decimal, shift and mask otherwise
  always_comb begin
    quot     = itar_pkg::VALUE_W'(prod >> itar_pkg::RECIP_SHIFT);
    q10_lo   = 4'(quot << 3) + 4'(quot << 1);
    rem      = num[3:0] - q10_lo;
    dmask    = 4'((5'd1 << shamt) - 5'd1);
    digit    = is_dec ? rem : (num[3:0] & dmask);
    num_next = is_dec ? quot : (num >> shamt);
    rd_addr  = cmd.emit_digit ? rd_idx - 1'b1 : rd_idx;
    out_free = !out_valid || out_ready;
  end

  always_comb begin
    status.op_ok    = op_ok;
    status.in_dec   = in_dec;
    status.dec      = is_dec;
    status.neg      = neg;
    status.done     = (num_next == '0) || (wr_idx == '1);
    status.rd_zero  = (rd_idx == '0);
    status.out_free = out_free;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      num    <= in_neg ? (~value + 1'b1) : value;
      shamt  <= in_shamt;
      is_dec <= in_dec;
      upper  <= (op == itar_pkg::OP_HEX_UP);
      neg    <= in_neg;
      wr_idx <= '0;
    end
    if (cmd.mul) begin
      prod <= (2*itar_pkg::VALUE_W)'(num) * (2*itar_pkg::VALUE_W)'(itar_pkg::RECIP_10);
    end
    if (cmd.digit) begin
      num    <= num_next;
      wr_idx <= wr_idx + 1'b1;
      rd_idx <= wr_idx;
    end
    if (cmd.emit_digit) begin
      rd_idx <= rd_idx - 1'b1;
    end
  end

  // digit store
  always_ff @(posedge clk) begin
    if (cmd.digit) begin
      mem[wr_idx] <= digit;
    end
    rd_data <= mem[rd_addr];
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.emit_sign || cmd.emit_digit) begin
      character <= cmd.emit_sign ? itar_pkg::CHAR_MINUS
                                 : itar_pkg::ascii_digit(rd_data, upper);
      last      <= cmd.emit_digit && (rd_idx == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      char_count <= '0;
    end else begin
      if (cmd.emit_sign || cmd.emit_digit) begin
        out_valid  <= 1'b1;
        char_count <= char_count + 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

[hdl/integer_to_ascii_radix.sv]
`timescale 1ns / 1ps
`default_nettype none

// channel   handshake            payload
// input     in_valid / in_ready  op[2:0], value[31:0]
// output    out_valid / out_ready character[7:0], last, char_count[31:0]
//
// A transaction goes through accept, D digit steps (each decimal step preceded by
// the registered reciprocal multiply), one store read, then its characters, one
// per cycle while the output is not stalled.
// The digit store is read once per character, which sets the emit rate.
// Reset clears the controller, output valid and the character count.
// A stalled output holds the current character and pauses emission; a new
// input is taken once the last character of the previous one is registered.

module integer_to_ascii_radix (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  op,
  input  logic [31:0] value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  character,
  output logic        last,
  output logic [31:0] char_count
);

  itar_pkg::cmd_t    cmd;
  itar_pkg::status_t status;

  itar_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  itar_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .op         (op),
    .value      (value),
    .cmd        (cmd),
    .status     (status),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .character  (character),
    .last       (last),
    .char_count (char_count)
  );

endmodule

`default_nettype wire

[hdl/itar_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module itar_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic [2:0]  op,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  character,
  input logic        last,
  input logic [31:0] char_count
);

  logic taken;
  logic legal_char;

  assign taken = out_valid && out_ready;
  assign legal_char = (character == 8'h2D)
                   || ((character >= 8'h30) && (character <= 8'h39))
                   || ((character >= 8'h41) && (character <= 8'h46))
                   || ((character >= 8'h61) && (character <= 8'h66));

  `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(character))
  // the count advances by exactly one per delivered character
  `ASSERT_NEXT(a_count_step, taken, !out_valid || (char_count == $past(char_count) + 32'd1))
  `ASSERT_SAME(a_legal_char, out_valid, legal_char)
  // a sign is always followed by at least one digit
  `ASSERT_SAME(a_sign_not_last, out_valid && (character == 8'h2D), !last)
  // a defined mode keeps the input closed while it converts
  `ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready && (op <= itar_pkg::OP_HEX_UP), !in_ready)

endmodule

bind integer_to_ascii_radix itar_checker u_itar_checker (.*);

`default_nettype wire

[dv/integer_to_ascii_radix_tb.sv]
`timescale 1ns / 1ps

module integer_to_ascii_radix_tb;

  localparam int          RUN_LIMIT  = 400000;
  localparam int          TAIL_WAIT  = 100;
  localparam int          BURST_LEN  = 37;
  localparam logic [2:0]  OP_UNDEF_A = 3'd6;
  localparam logic [2:0]  OP_UNDEF_B = 3'd7;

  typedef struct packed {
    logic [7:0]  ch;
    logic        lst;
    logic [31:0] cnt;
  } char_rec_t;

  class text_scoreboard;
    logic [31:0] char_total;
    char_rec_t   pending_chars[$];
    int          errors;

    function new();
      char_total = '0;
      errors = 0;
    endfunction

    // Render one number to its expected characters and queue them.
    function void note_number(logic [2:0] mode, logic [31:0] number);
      logic [31:0] mag;
      logic [31:0] radix;
      logic [3:0]  digit_buf [32];
      logic [7:0]  text[$];
      logic [7:0]  letter_base;
      logic        neg;
      int          ndig;
      char_rec_t   rec;
      mag = number;
      neg = 1'b0;
      ndig = 0;
      letter_base = itar_pkg::CHAR_LOWER;
      case (mode)
        itar_pkg::OP_BIN:    radix = 32'd2;
        itar_pkg::OP_OCT:    radix = 32'd8;
        itar_pkg::OP_UDEC:   radix = 32'd10;
        itar_pkg::OP_SDEC:   radix = 32'd10;
        itar_pkg::OP_HEX_LO: radix = 32'd16;
        itar_pkg::OP_HEX_UP: begin
          radix = 32'd16;
          letter_base = itar_pkg::CHAR_UPPER;
        end
        default:   return;
      endcase
      if (mode == itar_pkg::OP_SDEC && number[31]) begin
        neg = 1'b1;
        mag = -number;
      end
      do begin
        digit_buf[ndig] = 4'(mag % radix);
        ndig++;
        mag = mag / radix;
      end while (mag != 0 && ndig < 32);
      if (neg) text.push_back(itar_pkg::CHAR_MINUS);
      for (int k = ndig - 1; k >= 0; k--) begin
        if (text.size() >= 32) break;
        if (digit_buf[k] < 4'd10) text.push_back(itar_pkg::CHAR_ZERO + {4'd0, digit_buf[k]});
        else text.push_back(letter_base + {4'd0, digit_buf[k]} - 8'd10);
      end
      foreach (text[i]) begin
        char_total = char_total + 32'd1;
        rec.ch  = text[i];
        rec.lst = (i == text.size() - 1);
        rec.cnt = char_total;
        pending_chars.push_back(rec);
      end
    endfunction

    function void check_char(logic [7:0] ch, logic lst, logic [31:0] cnt);
      char_rec_t want;
      if (pending_chars.size() == 0) begin
        errors++;
        $display("%0t: unexpected character: expected none, actual char %h last %b count %0d",
                 $time, ch, lst, cnt);
        return;
      end
      want = pending_chars.pop_front();
      if (ch !== want.ch) begin
        errors++;
        $display("%0t: character mismatch: expected %h, actual %h", $time, want.ch, ch);
      end
      if (lst !== want.lst) begin
        errors++;
        $display("%0t: last mismatch: expected %b, actual %b", $time, want.lst, lst);
      end
      if (cnt !== want.cnt) begin
        errors++;
        $display("%0t: char_count mismatch: expected %0d, actual %0d", $time, want.cnt, cnt);
      end
    endfunction

    function int pending();
      return pending_chars.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  op = itar_pkg::OP_BIN;
  logic [31:0] value = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  character;
  logic        last;
  logic [31:0] char_count;

  int             send_idle_pct = 33;
  int             recv_idle_pct = 69;
  int             cycle_count = 0;
  text_scoreboard sb = new();

  integer_to_ascii_radix dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .op         (op),
    .value      (value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .character  (character),
    .last       (last),
    .char_count (char_count)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Note inputs before checking outputs so a same-edge pair stays ordered.
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) sb.note_number(op, value);
    if (!rst && out_valid && out_ready) sb.check_char(character, last, char_count);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_number(input logic [2:0] mode, input logic [31:0] number);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    op       <= mode;
    value    <= number;
    do @(posedge clk); while (!in_ready);
  endtask

  // Hold off the sender until every queued character has come out.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 32'($urandom_range(0, 15));
      1: return 32'($urandom_range(0, 9999));
      2: return 32'h8000_0000 + 32'($urandom_range(0, 3)) - 32'd2;
      3: return 32'd1 << $urandom_range(0, 31);
      4: return 32'hFFFF_FFFF - 32'($urandom_range(0, 15));
      default: return $urandom();
    endcase
  endfunction

  task automatic random_burst(input int count);
    int sent;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 11) == 0) begin
        send_number($urandom_range(0, 1) ? OP_UNDEF_A : OP_UNDEF_B, $urandom());
      end else begin
        send_number(3'($urandom_range(itar_pkg::OP_BIN, itar_pkg::OP_HEX_UP)), pick_value());
        sent++;
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    send_number(itar_pkg::OP_BIN,    32'h0000_0000);
    send_number(itar_pkg::OP_BIN,    32'hFFFF_FFFF);
    send_number(itar_pkg::OP_BIN,    32'h8000_0000);
    send_number(itar_pkg::OP_OCT,    32'h0000_0000);
    send_number(itar_pkg::OP_OCT,    32'hFFFF_FFFF);
    send_number(itar_pkg::OP_UDEC,   32'h0000_0000);
    send_number(itar_pkg::OP_UDEC,   32'hFFFF_FFFF);
    send_number(itar_pkg::OP_UDEC,   32'd9);
    send_number(itar_pkg::OP_SDEC,   32'h0000_0000);
    send_number(itar_pkg::OP_SDEC,   32'hFFFF_FFFF);
    send_number(itar_pkg::OP_SDEC,   32'h8000_0000);
    send_number(itar_pkg::OP_SDEC,   32'h7FFF_FFFF);
    send_number(itar_pkg::OP_SDEC,   32'd1);
    send_number(itar_pkg::OP_HEX_LO, 32'h0000_0000);
    send_number(itar_pkg::OP_HEX_LO, 32'hFFFF_FFFF);
    send_number(itar_pkg::OP_HEX_LO, 32'hFEDC_BA98);
    send_number(itar_pkg::OP_HEX_UP, 32'h0000_0000);
    send_number(itar_pkg::OP_HEX_UP, 32'hFFFF_FFFF);
    send_number(itar_pkg::OP_HEX_UP, 32'hFEDC_BA98);
    send_number(OP_UNDEF_A, 32'hFFFF_FFFF);
    send_number(OP_UNDEF_B, 32'h0000_0000);

    random_burst(BURST_LEN);
    drain();

    send_idle_pct = 69;
    recv_idle_pct = 33;
    random_burst(BURST_LEN);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_burst(BURST_LEN);
    drain();
    repeat (TAIL_WAIT) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
